// File: src/skm_pkg.sv
// Shared constants, types and helpers for the super-k-mer minimizer splitter.
`timescale 1ns / 1ps
`default_nettype none

package skm_pkg;

  // Field widths
  localparam int SYM_W   = 8;
  localparam int CODE_W  = 2;
  localparam int LEN_W   = 5;
  localparam int VAL_W   = 62;
  localparam int CFG_IDX_W = 1;

  // ASCII characters of the sequence
  localparam logic [SYM_W-1:0] SYM_A  = 8'h41;
  localparam logic [SYM_W-1:0] SYM_C  = 8'h43;
  localparam logic [SYM_W-1:0] SYM_T  = 8'h54;
  localparam logic [SYM_W-1:0] SYM_G  = 8'h47;
  localparam logic [SYM_W-1:0] SYM_N  = 8'h4E;
  localparam logic [SYM_W-1:0] SYM_LF = 8'h0A;

  // Nucleotide codes
  localparam logic [CODE_W-1:0] CODE_A = 2'd0;
  localparam logic [CODE_W-1:0] CODE_C = 2'd1;
  localparam logic [CODE_W-1:0] CODE_T = 2'd2;
  localparam logic [CODE_W-1:0] CODE_G = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_KMER_LEN = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MMER_LEN = 1'd1;

  // Reset values of the length registers
  localparam logic [LEN_W-1:0] KMER_LEN_RST = 5'd31;
  localparam logic [LEN_W-1:0] MMER_LEN_RST = 5'd11;

  // Low bit of every base-4 digit
  localparam logic [VAL_W-1:0] DIGIT_LOW = 62'h1555555555555555;

  typedef logic [VAL_W-1:0] value_t;

  // Swap digit codes 2 and 3 so that plain compare gives A < C < G < T
  function automatic value_t alpha_rank(input value_t v);
    return v ^ ((v >> 1) & DIGIT_LOW);
  endfunction

endpackage

`default_nettype wire

// File: src/superkmer_minimizer_splitter.sv
// Top level: rolling k-mer, m-mer window in a ring memory and minimizer tracking.
// Flow: a nucleotide goes through S_DECIDE, which registers its result or starts a
//   rescan; an unknown character's result is registered as it is taken; N and newline give none.
// Input: a new character is taken only in S_IDLE, so one at a time; a minimizer rescan
//   reads n = k-m+1 entries through the single window memory read port.
// Reset: synchronous, clears the k-mer, minimizer and fill count, loads k=31, m=11.
`timescale 1ns / 1ps
`default_nettype none

module superkmer_minimizer_splitter
  import skm_pkg::*;
#(
  parameter int MAX_K = 31
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  // Character channel
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [SYM_W-1:0]     symbol,
  // Result channel
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [CODE_W-1:0]         base_code,
  output logic                      kmer_ready,
  output logic                      new_superkmer,
  output logic [VAL_W-1:0]          kmer_value,
  output logic [VAL_W-1:0]          minimizer_value,
  output logic                      bad_symbol,
  // Configuration write channel
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [LEN_W-1:0]     cfg_data
);

  localparam int PW = (MAX_K > 1) ? $clog2(MAX_K) : 1;
  localparam int CW = $clog2(MAX_K + 1);
  localparam logic [PW-1:0]    HEAD_LAST = PW'(MAX_K - 1);
  localparam logic [LEN_W-1:0] K_LIMIT   = LEN_W'(MAX_K);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECIDE,
    S_SCAN
  } state_t;

  // Step back d entries from h around the ring
  function automatic logic [PW-1:0] ring_back(input logic [PW-1:0] h,
                                              input logic [PW-1:0] d);
    logic [PW:0] diff;
    diff = {1'b0, h} - {1'b0, d};
    if (diff[PW]) begin
      diff = diff + (PW+1)'(MAX_K);
    end
    return diff[PW-1:0];
  endfunction

  state_t             state;
  logic [LEN_W-1:0]   kmer_length;
  logic [LEN_W-1:0]   mmer_length;
  value_t             kmer_reg;
  value_t             cur_min;
  logic [LEN_W-1:0]   fill_count;
  logic [PW-1:0]      head;
  value_t             newm;
  logic [CODE_W-1:0]  code_q;
  logic               ready_q;
  logic               prev_full;
  logic               full_start;
  logic [CW-1:0]      issue_cnt;
  logic [CW-1:0]      recv_cnt;
  logic               rd_pending;
  value_t             best;

  value_t             window_mem [MAX_K];
  value_t             rd_data;

  // Effective lengths and masks
  logic [LEN_W-1:0]   k_eff;
  logic [LEN_W-1:0]   m_eff;
  logic [LEN_W-1:0]   n_len;
  value_t             kmask;
  value_t             mmask;

  always_comb begin
    k_eff = (kmer_length == '0) ? LEN_W'(1) : kmer_length;
    if (k_eff > K_LIMIT) begin
      k_eff = K_LIMIT;
    end
    m_eff = (mmer_length == '0) ? LEN_W'(1) : mmer_length;
    if (m_eff > k_eff) begin
      m_eff = k_eff;
    end
    n_len = k_eff - m_eff + LEN_W'(1);
    kmask = {VAL_W{1'b1}} >> (7'd62 - {1'b0, k_eff, 1'b0});
    mmask = {VAL_W{1'b1}} >> (7'd62 - {1'b0, m_eff, 1'b0});
  end

  // Decode the character
  logic              is_skip;
  logic              is_base;
  logic [CODE_W-1:0] code;

  always_comb begin
    is_skip = (symbol == SYM_N) || (symbol == SYM_LF);
    is_base = 1'b1;
    case (symbol)
      SYM_A:   code = CODE_A;
      SYM_C:   code = CODE_C;
      SYM_T:   code = CODE_T;
      SYM_G:   code = CODE_G;
      default: begin
        code    = CODE_A;
        is_base = 1'b0;
      end
    endcase
  end

  // Handshakes; a pending configuration write holds off the character channel
  logic accept;
  logic accept_base;
  logic bad_load;
  logic cfg_write;

  assign in_stall    = !((state == S_IDLE) && !cfg_valid && (!out_valid || !out_stall));
  assign cfg_ready   = (state == S_IDLE);
  assign accept      = in_valid && !in_stall;
  assign accept_base = accept && is_base;
  assign bad_load    = accept && !is_skip && !is_base;
  assign cfg_write   = cfg_valid && cfg_ready;

  // Shift in the new nucleotide
  value_t           kmer_shift;
  value_t           newm_c;
  logic [LEN_W-1:0] fill_next;
  logic [PW-1:0]    head_next;

  always_comb begin
    kmer_shift = {kmer_reg[VAL_W-3:0], code} & kmask;
    newm_c     = kmer_shift & mmask;
    fill_next  = (fill_count < k_eff) ? fill_count + LEN_W'(1) : k_eff;
    head_next  = (head == HEAD_LAST) ? '0 : head + PW'(1);
  end

  // Window memory addressing
  logic          issue_more;
  logic          mem_re;
  logic [PW-1:0] mem_raddr;

  assign issue_more = (state == S_SCAN) && (LEN_W'(issue_cnt) < n_len);
  assign mem_re     = accept_base || issue_more;
  assign mem_raddr  = (state == S_SCAN) ? ring_back(head, issue_cnt[PW-1:0])
                                        : ring_back(head, PW'(n_len - LEN_W'(1)));

  // Window memory: write the new m-mer, read the dropped one or a scan entry
  always_ff @(posedge clk) begin
    if (accept_base) begin
      window_mem[head_next] <= newm_c;
    end
    if (mem_re) begin
      rd_data <= window_mem[mem_raddr];
    end
  end

  // Running least m-mer of the rescan
  value_t scan_pick;
  logic   scan_last;
  logic   newm_less;

  always_comb begin
    scan_pick = ((recv_cnt == '0) || (alpha_rank(rd_data) < alpha_rank(best)))
                ? rd_data : best;
    scan_last = (LEN_W'(recv_cnt) == n_len - LEN_W'(1));
    newm_less = alpha_rank(newm) < alpha_rank(cur_min);
  end

  // Sequencer, state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      kmer_length <= KMER_LEN_RST;
      mmer_length <= MMER_LEN_RST;
      kmer_reg    <= '0;
      cur_min     <= '0;
      fill_count  <= '0;
      head        <= '0;
      out_valid   <= 1'b0;
      rd_pending  <= 1'b0;
      issue_cnt   <= '0;
      recv_cnt    <= '0;
    end else begin
      // Drop the result once taken
      if (out_valid && !out_stall && !bad_load) begin
        out_valid <= 1'b0;
      end
      rd_pending <= issue_more;

      case (state)
        S_IDLE: begin
          if (accept && !is_skip) begin
            if (is_base) begin
              kmer_reg   <= kmer_shift;
              newm       <= newm_c;
              code_q     <= code;
              fill_count <= fill_next;
              head       <= head_next;
              ready_q    <= (fill_next == k_eff);
              prev_full  <= (fill_count >= k_eff);
              state      <= S_DECIDE;
            end else begin
              out_valid       <= 1'b1;
              base_code       <= CODE_A;
              kmer_ready      <= 1'b0;
              new_superkmer   <= 1'b0;
              kmer_value      <= '0;
              minimizer_value <= '0;
              bad_symbol      <= 1'b1;
            end
          end
        end

        S_DECIDE: begin
          base_code  <= code_q;
          kmer_value <= kmer_reg;
          bad_symbol <= 1'b0;
          kmer_ready <= ready_q;
          issue_cnt  <= '0;
          recv_cnt   <= '0;
          if (!ready_q) begin
            out_valid       <= 1'b1;
            new_superkmer   <= 1'b0;
            minimizer_value <= '0;
            state           <= S_IDLE;
          end else if (!prev_full) begin
            full_start <= 1'b1;
            state      <= S_SCAN;
          end else if (newm_less) begin
            cur_min         <= newm;
            out_valid       <= 1'b1;
            new_superkmer   <= 1'b1;
            minimizer_value <= newm;
            state           <= S_IDLE;
          end else if (cur_min == rd_data) begin
            full_start <= 1'b0;
            state      <= S_SCAN;
          end else begin
            out_valid       <= 1'b1;
            new_superkmer   <= 1'b0;
            minimizer_value <= cur_min;
            state           <= S_IDLE;
          end
        end

        S_SCAN: begin
          if (issue_more) begin
            issue_cnt <= issue_cnt + CW'(1);
          end
          if (rd_pending) begin
            best     <= scan_pick;
            recv_cnt <= recv_cnt + CW'(1);
            if (scan_last) begin
              cur_min         <= scan_pick;
              out_valid       <= 1'b1;
              new_superkmer   <= full_start || (scan_pick != cur_min);
              minimizer_value <= scan_pick;
              state           <= S_IDLE;
            end
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase

      // Length write restarts the warm-up
      if (cfg_write) begin
        if (cfg_index == REG_KMER_LEN) begin
          kmer_length <= cfg_data;
        end else begin
          mmer_length <= cfg_data;
        end
        kmer_reg   <= '0;
        cur_min    <= '0;
        fill_count <= '0;
      end
    end
  end

  // Checks
  a_newsk_needs_ready: assert property (@(posedge clk) disable iff (rst)
    out_valid && new_superkmer |-> kmer_ready)
    else $error("new super-k-mer flagged before the k-mer is full");

  a_bad_result_clear: assert property (@(posedge clk) disable iff (rst)
    out_valid && bad_symbol |-> !kmer_ready && !new_superkmer && kmer_value == '0)
    else $error("unknown-character result carries nonzero fields");

  a_fill_bounded: assert property (@(posedge clk) disable iff (rst)
    fill_count <= k_eff)
    else $error("fill count above k");

  a_scan_order: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> recv_cnt <= issue_cnt)
    else $error("scan received more entries than it read");

endmodule

`default_nettype wire

// File: sim/testbench.sv
// Self-checking testbench for the super-k-mer minimizer splitter: random DNA streams per k/m setting.
`timescale 1ns / 1ps
`default_nettype none

module testbench;
  import skm_pkg::*;

  localparam int WINDOW_DEPTH  = 31;
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int LONG_HOLDOFF  = 400;

  typedef struct packed {
    logic [CODE_W-1:0] base_code;
    logic              kmer_ready;
    logic              new_superkmer;
    value_t            kmer_value;
    value_t            minimizer_value;
    logic              bad_symbol;
  } result_t;

  // Track the rolling k-mer, the m-mer window and the minimizer; hold expected results
  class minimizer_tracker;
    logic [LEN_W-1:0] kmer_len;
    logic [LEN_W-1:0] mmer_len;
    logic [63:0]      kmer_reg;
    logic [63:0]      mmer_hist [WINDOW_DEPTH];
    logic [63:0]      minimizer;
    int unsigned      filled;
    result_t          expected_results [$];
    int unsigned      error_count;

    function new();
      kmer_len = KMER_LEN_RST;
      mmer_len = MMER_LEN_RST;
      restart_warmup();
      foreach (mmer_hist[i]) mmer_hist[i] = '0;
      error_count = 0;
    endfunction

    function void restart_warmup();
      kmer_reg  = '0;
      minimizer = '0;
      filled    = 0;
    endfunction

    // Swap digits 2 and 3 so that a plain compare follows A < C < G < T
    function logic [63:0] sort_key(logic [63:0] v);
      return v ^ ((v >> 1) & {2'b00, DIGIT_LOW});
    endfunction

    function logic [63:0] least_in_window(int unsigned span);
      logic [63:0] best;
      best = mmer_hist[0];
      for (int i = 1; i < span; i++)
        if (sort_key(mmer_hist[i]) < sort_key(best)) best = mmer_hist[i];
      return best;
    endfunction

    function void write_length(logic [CFG_IDX_W-1:0] idx, logic [LEN_W-1:0] data);
      case (idx)
        REG_KMER_LEN: kmer_len = data;
        REG_MMER_LEN: mmer_len = data;
        default: ;
      endcase
      restart_warmup();
    endfunction

    // Note an accepted request and queue the result it causes
    function void take_symbol(logic [SYM_W-1:0] sym);
      result_t           res;
      logic [CODE_W-1:0] code;
      int unsigned       k, m, span, prev_fill;
      logic [63:0]       kmask, mmask, newest, dropped, old_min;
      if (sym == SYM_N || sym == SYM_LF) return;
      res = '0;
      case (sym)
        SYM_A: code = CODE_A;
        SYM_C: code = CODE_C;
        SYM_T: code = CODE_T;
        SYM_G: code = CODE_G;
        default: begin
          res.bad_symbol = 1'b1;
          expected_results.push_back(res);
          return;
        end
      endcase
      // Clamp the lengths the way the block does
      k = (kmer_len == 0) ? 1 : kmer_len;
      if (k > WINDOW_DEPTH) k = WINDOW_DEPTH;
      m = (mmer_len == 0) ? 1 : mmer_len;
      if (m > k) m = k;
      span  = k - m + 1;
      kmask = (64'd1 << (2 * k)) - 64'd1;
      mmask = (64'd1 << (2 * m)) - 64'd1;
      // Shift the base in and advance the window
      kmer_reg = ((kmer_reg << 2) | code) & kmask;
      newest   = kmer_reg & mmask;
      dropped  = mmer_hist[span - 1];
      for (int i = WINDOW_DEPTH - 1; i > 0; i--) mmer_hist[i] = mmer_hist[i - 1];
      mmer_hist[0] = newest;
      prev_fill = filled;
      if (filled < k) filled++;
      if (filled > k) filled = k;
      res.base_code  = code;
      res.kmer_value = kmer_reg[VAL_W-1:0];
      // Update the minimizer once the k-mer is full
      if (filled == k) begin
        res.kmer_ready = 1'b1;
        if (prev_fill < k) begin
          minimizer = least_in_window(span);
          res.new_superkmer = 1'b1;
        end else begin
          old_min = minimizer;
          if (sort_key(newest) < sort_key(old_min)) minimizer = newest;
          else if (old_min == dropped) minimizer = least_in_window(span);
          res.new_superkmer = (minimizer != old_min);
        end
        res.minimizer_value = minimizer[VAL_W-1:0];
      end
      expected_results.push_back(res);
    endfunction

    function void match_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        error_count++;
      end
    endfunction

    // Check an accepted result against the oldest expectation
    function void compare_result(result_t got);
      result_t want;
      if (expected_results.size() == 0) begin
        $display("%0t: result with no request pending, expected none, actual %h", $time, got);
        error_count++;
        return;
      end
      want = expected_results.pop_front();
      match_field("base_code", want.base_code, got.base_code);
      match_field("kmer_ready", want.kmer_ready, got.kmer_ready);
      match_field("new_superkmer", want.new_superkmer, got.new_superkmer);
      match_field("kmer_value", want.kmer_value, got.kmer_value);
      match_field("minimizer_value", want.minimizer_value, got.minimizer_value);
      match_field("bad_symbol", want.bad_symbol, got.bad_symbol);
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [SYM_W-1:0]     symbol = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [CODE_W-1:0]    base_code;
  logic                 kmer_ready;
  logic                 new_superkmer;
  logic [VAL_W-1:0]     kmer_value;
  logic [VAL_W-1:0]     minimizer_value;
  logic                 bad_symbol;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [LEN_W-1:0]     cfg_data = '0;

  minimizer_tracker tracker;
  result_t          observed;
  int unsigned      tx_idle_pct = 0;
  int unsigned      rx_stall_pct = 0;
  int unsigned      holdoff_requests = 0;
  int unsigned      holdoff_served = 0;
  int unsigned      holdoff_left = 0;
  int unsigned      cycle_count = 0;
  logic [SYM_W-1:0] bases [4] = '{SYM_A, SYM_C, SYM_T, SYM_G};

  superkmer_minimizer_splitter DUT (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .symbol          (symbol),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .base_code       (base_code),
    .kmer_ready      (kmer_ready),
    .new_superkmer   (new_superkmer),
    .kmer_value      (kmer_value),
    .minimizer_value (minimizer_value),
    .bad_symbol      (bad_symbol),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always #5 clk = ~clk;

  // Stall the result channel: long hold-off on request, random otherwise
  always @(negedge clk) begin
    if (holdoff_left > 0) begin
      out_stall <= 1'b1;
      holdoff_left <= holdoff_left - 1;
    end else if (holdoff_served != holdoff_requests) begin
      holdoff_served <= holdoff_served + 1;
      holdoff_left <= LONG_HOLDOFF;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_stall_pct);
    end
  end

  // Check every accepted result
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      observed = {base_code, kmer_ready, new_superkmer, kmer_value, minimizer_value,
                  bad_symbol};
      tracker.compare_result(observed);
    end
  end

  // Drive one request; idle first at the sender's rate
  task automatic send_symbol(input logic [SYM_W-1:0] sym);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    symbol <= sym;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.take_symbol(sym);
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_symbol(s[i]);
  endtask

  // Hold the sender until every expected result is in, then let the block settle
  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (tracker.expected_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_length(input logic [CFG_IDX_W-1:0] idx, input logic [LEN_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    tracker.write_length(idx, val);
    @(negedge clk);
  endtask

  task automatic set_lengths(input logic [LEN_W-1:0] k, input logic [LEN_W-1:0] m);
    write_length(REG_KMER_LEN, k);
    write_length(REG_MMER_LEN, m);
    cfg_valid <= 1'b0;
  endtask

  // Mostly bases, some skipped characters, some arbitrary bytes
  function automatic logic [SYM_W-1:0] pick_symbol(bit narrow);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 86) return bases[$urandom_range(narrow ? 1 : 3)];
    if (r < 93) return $urandom_range(1) ? SYM_N : SYM_LF;
    return 8'($urandom_range(255));
  endfunction

  task automatic run_phase(input logic [LEN_W-1:0] k, input logic [LEN_W-1:0] m,
                           input int unsigned tx, input int unsigned rx,
                           input int unsigned count, input bit pressure);
    int unsigned      taken;
    bit               narrow;
    logic [SYM_W-1:0] sym;
    taken = 0;
    narrow = 1'b0;
    wait_for_results();
    set_lengths(k, m);
    tx_idle_pct = tx;
    rx_stall_pct = rx;
    if (pressure) holdoff_requests++;
    while (taken < count) begin
      // Switch now and then to a two-letter alphabet for long runs and ties
      if ($urandom_range(39) == 0) narrow = !narrow;
      sym = pick_symbol(narrow);
      send_symbol(sym);
      if (sym != SYM_N && sym != SYM_LF) taken++;
    end
  endtask

  // Bound the run
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    tracker = new();
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: reset lengths with skipped and unknown characters, then short k
    send_text("ACGTN\n");
    send_symbol(8'h00);
    send_symbol(8'hFF);
    wait_for_results();
    set_lengths(5'd4, 5'd2);
    send_text("GGATTCA\nCGTAAcG");

    // Random phases over length settings and idling patterns
    run_phase(5'd31, 5'd11, 0, 0, 120, 1'b0);
    run_phase(5'd1, 5'd1, 78, 0, 60, 1'b0);
    run_phase(5'd2, 5'd1, 0, 78, 60, 1'b0);
    run_phase(5'd31, 5'd1, 14, 14, 100, 1'b0);
    run_phase(5'd31, 5'd31, 0, 0, 60, 1'b0);
    run_phase(5'd5, 5'd31, 0, 78, 60, 1'b0);
    run_phase(5'd0, 5'd0, 14, 14, 40, 1'b0);
    run_phase(5'd8, 5'd3, 0, 0, 100, 1'b1);
    run_phase(5'd12, 5'd4, 78, 0, 80, 1'b0);
    run_phase(5'd20, 5'd7, 0, 78, 80, 1'b0);
    run_phase(5'd31, 5'd16, 14, 14, 80, 1'b0);

    wait_for_results();
    if (tracker.error_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

`default_nettype wire

// File: filelist.f
src/skm_pkg.sv
src/superkmer_minimizer_splitter.sv
sim/testbench.sv
